// ===== hw/rtl/fpm_pkg.sv =====
// fpm_pkg: shared types and constants for the single-precision multiplier
// no dependencies
`timescale 1ns / 1ps
package fpm_pkg;
  localparam int ExpBias = 127;
  localparam int ExpMax  = 255;
  localparam logic [30:0] InfBits = 31'h7F800000;

  // stage 1 result: unpacked operands, early outcome
  typedef struct packed {
    logic        sign;
    logic [9:0]  exp;      // biased exponent, valid when not early
    logic [23:0] ma;
    logic [23:0] mb;
    logic        early;    // result already decided
    logic [31:0] early_bits;
    logic        early_ovf;
    logic        early_unf;
  } fpm_unp_t;

  // stage 2 result: raw product
  typedef struct packed {
    logic        sign;
    logic [9:0]  exp;
    logic [47:0] prod;
    logic        early;
    logic [31:0] early_bits;
    logic        early_ovf;
    logic        early_unf;
  } fpm_mul_t;

  // stage 3 result: normalized product
  typedef struct packed {
    logic        sign;
    logic [9:0]  exp;
    logic [47:0] prod;
    logic        lost;
    logic        early;
    logic [31:0] early_bits;
    logic        early_ovf;
    logic        early_unf;
  } fpm_nrm_t;
endpackage

// ===== hw/rtl/fpm_if.sv =====
// fpm_if: valid/ready channel carrying a generic payload
// depends on nothing
`timescale 1ns / 1ps
interface fpm_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fpm_unpack.sv =====
// fpm_unpack: operand decode, exponent sum and early outcomes
// depends on fpm_pkg
`timescale 1ns / 1ps
module fpm_unpack (
  input  logic [31:0]      operand_a,
  input  logic [31:0]      operand_b,
  output fpm_pkg::fpm_unp_t unp
);
  import fpm_pkg::*;
  logic [7:0] ea, eb;
  logic [22:0] fa, fb;
  logic [9:0] exp;
  logic sign;

  always_comb begin
    ea = operand_a[30:23];
    eb = operand_b[30:23];
    fa = operand_a[22:0];
    fb = operand_b[22:0];
    sign = operand_a[31] ^ operand_b[31];
    // signed 10-bit: range -125..383
    exp = 10'((ea == 8'd0) ? 10'd1 : {2'b0, ea}) + 10'((eb == 8'd0) ? 10'd1 : {2'b0, eb})
          - 10'(ExpBias);
    unp.sign = sign;
    unp.exp = exp;
    unp.ma = {ea != 8'd0, fa};
    unp.mb = {eb != 8'd0, fb};
    unp.early = 1'b0;
    unp.early_bits = 32'd0;
    unp.early_ovf = 1'b0;
    unp.early_unf = 1'b0;
    if ((ea == 8'd0 && fa == 23'd0) || (eb == 8'd0 && fb == 23'd0)) begin
      unp.early = 1'b1;
    end else if (!exp[9] && exp >= 10'(ExpMax)) begin
      unp.early = 1'b1;
      unp.early_bits = {sign, InfBits};
      unp.early_ovf = 1'b1;
    end else if (exp[9] || exp == 10'd0) begin
      unp.early = 1'b1;
      unp.early_bits = {sign, 31'd0};
      unp.early_unf = 1'b1;
    end
  end
endmodule

// ===== hw/rtl/fpm_normalize.sv =====
// fpm_normalize: one right step or leading-zero left shift clamped at exponent 1
// depends on fpm_pkg
`timescale 1ns / 1ps
module fpm_normalize (
  input  fpm_pkg::fpm_mul_t mul,
  output fpm_pkg::fpm_nrm_t nrm
);
  import fpm_pkg::*;
  logic [5:0] lz;
  logic [9:0] room, sh;

  // leading zeros counted from bit 46
  always_comb begin
    lz = 6'd47;
    for (int i = 0; i <= 46; i++) begin
      if (mul.prod[i]) lz = 6'(46 - i);
    end
  end

  always_comb begin
    room = mul.exp - 10'd1;
    sh = ({4'd0, lz} < room) ? {4'd0, lz} : room;
    nrm.sign = mul.sign;
    nrm.early = mul.early;
    nrm.early_bits = mul.early_bits;
    nrm.early_ovf = mul.early_ovf;
    nrm.early_unf = mul.early_unf;
    if (mul.prod[47]) begin
      nrm.prod = mul.prod >> 1;
      nrm.lost = mul.prod[0];
      nrm.exp = mul.exp + 10'd1;
    end else begin
      nrm.prod = mul.prod << sh[5:0];
      nrm.lost = 1'b0;
      nrm.exp = mul.exp - sh;
    end
  end
endmodule

// ===== hw/rtl/fpm_round.sv =====
// fpm_round: pack, round to nearest even, final overflow check
// depends on fpm_pkg
`timescale 1ns / 1ps
module fpm_round (
  input  fpm_pkg::fpm_nrm_t nrm,
  output logic [31:0]       product,
  output logic              overflow_flag,
  output logic              underflow_flag
);
  import fpm_pkg::*;
  logic [31:0] base;
  logic rnd, sticky;

  always_comb begin
    base = {9'd0, nrm.prod[45:23]};
    if (nrm.prod[46]) base[31:23] = {1'b0, nrm.exp[7:0]};
    rnd = nrm.prod[22];
    sticky = (nrm.prod[21:0] != 22'd0) || nrm.lost;
    if (rnd && (sticky || base[0])) base = base + 32'd1;
    product = {nrm.sign, base[30:0]};
    overflow_flag = 1'b0;
    underflow_flag = 1'b0;
    if (nrm.early) begin
      product = nrm.early_bits;
      overflow_flag = nrm.early_ovf;
      underflow_flag = nrm.early_unf;
    end else if (nrm.exp >= 10'(ExpMax) || base[31:23] >= 9'(ExpMax)) begin
      product = {nrm.sign, InfBits};
      overflow_flag = 1'b1;
    end
  end
endmodule

// ===== hw/rtl/fp32_multiply_core.sv =====
// channel | dir | payload
// in      | in  | operand_a[31:0], operand_b[31:0]
// out     | out | product[31:0], overflow_flag, underflow_flag
// four register stages: unpack, 24x24 multiply, normalize, round/output.
// one word per cycle while the output is not stalled.
// a stall freezes every stage that holds a word ahead of a full stage.
// rst clears all valid bits synchronously.
`timescale 1ns / 1ps
module fp32_multiply_core (
  input logic clk,
  input logic rst,
  fpm_if.sink   in,
  fpm_if.source out
);
  import fpm_pkg::*;
  fpm_unp_t unp_c, unp_r;
  fpm_mul_t mul_r;
  fpm_nrm_t nrm_c, nrm_r;
  logic [31:0] prod_c;
  logic ovf_c, unf_c;
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  fpm_unpack u_unp (.operand_a(in.data.operand_a), .operand_b(in.data.operand_b), .unp(unp_c));
  fpm_normalize u_nrm (.mul(mul_r), .nrm(nrm_c));
  fpm_round u_rnd (.nrm(nrm_r), .product(prod_c), .overflow_flag(ovf_c),
                   .underflow_flag(unf_c));

  // stall chain
  assign en4 = !v4 || out.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in.ready = en1;
  assign out.valid = v4;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en1) unp_r <= unp_c;
    if (en2) begin
      mul_r.sign <= unp_r.sign;
      mul_r.exp <= unp_r.exp;
      mul_r.prod <= unp_r.ma * unp_r.mb;
      mul_r.early <= unp_r.early;
      mul_r.early_bits <= unp_r.early_bits;
      mul_r.early_ovf <= unp_r.early_ovf;
      mul_r.early_unf <= unp_r.early_unf;
    end
    if (en3) nrm_r <= nrm_c;
    if (en4) begin
      out.data.product <= prod_c;
      out.data.overflow_flag <= ovf_c;
      out.data.underflow_flag <= unf_c;
    end
  end

  // flags never both set
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !(out.data.overflow_flag && out.data.underflow_flag))
    else $error("both flags set");
  // overflow carries infinity
  a_inf: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.data.overflow_flag) |-> out.data.product[30:0] == InfBits)
    else $error("overflow without infinity");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> out.valid && $stable(out.data.product))
    else $error("output changed under stall");
endmodule
